>>> rtl/core/hrtoc_pkg.sv
// ----------------------------------------------------------------------------
// hrtoc_pkg
// Shared types and constants of the heater relay controller with timed
// auto-off: request and result records, controller state, mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hrtoc_pkg;

  // default timer tick rate
  localparam int unsigned TICKS_PER_SECOND = 1000;

  // operation codes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // operating modes
  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_ON     = 3'd1;
  localparam logic [2:0] MODE_OFF30  = 3'd2;
  localparam logic [2:0] MODE_OFF60  = 3'd3;
  localparam logic [2:0] MODE_CUSTOM = 3'd4;

  // report kinds
  localparam logic [1:0] REPORT_NONE    = 2'd0;
  localparam logic [1:0] REPORT_CHANGED = 2'd1;
  localparam logic [1:0] REPORT_SECONDS = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CUSTOM_OFF_SECONDS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_DELAY_TICKS   = 1'd1;

  // reset values of the configuration registers
  localparam logic [15:0] CUSTOM_OFF_SECONDS_RST = 16'd10;
  localparam logic [15:0] SYNC_DELAY_TICKS_RST   = 16'd100;

  // fixed timed-mode lengths in seconds
  localparam logic [15:0] OFF30_SECONDS = 16'd1800;
  localparam logic [15:0] OFF60_SECONDS = 16'd3600;

  typedef struct packed {
    logic       opcode;
    logic [2:0] mode;
  } in_t;

  typedef struct packed {
    logic        relay_start;
    logic        relay_sync;
    logic [1:0]  report_kind;
    logic [2:0]  report_mode;
    logic [15:0] remaining_seconds;
  } out_t;

  // controller state; the timer counts whole seconds plus a sub-second
  // count kept next to this record
  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  cmd_rec;
    logic [2:0]  rep_rec;
    logic [15:0] sync_cnt;
    logic        sync_armed;
    logic        timer_run;
    logic [15:0] secs_total;
    logic [15:0] secs_done;
    logic        relay_start;
    logic        relay_sync;
  } state_t;

  // state after reset: sync armed, everything else cleared
  localparam state_t STATE_RST = '{sync_armed: 1'b1, default: '0};

endpackage

`default_nettype wire

>>> rtl/core/hrtoc_step.sv
// ----------------------------------------------------------------------------
// hrtoc_step
// Next-state and result logic for one request: a mode command or one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module hrtoc_step #(
  parameter int unsigned TICKS_PER_SECOND = hrtoc_pkg::TICKS_PER_SECOND,
  localparam int unsigned SubW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1
) (
  input  wire hrtoc_pkg::in_t    req_i,
  input  wire hrtoc_pkg::state_t st_i,
  input  wire logic [SubW-1:0]   sub_i,
  input  wire logic [15:0]       custom_off_seconds_i,
  input  wire logic [15:0]       sync_delay_ticks_i,
  output hrtoc_pkg::state_t      st_o,
  output logic [SubW-1:0]        sub_o,
  output hrtoc_pkg::out_t        rsp_o
);

  localparam logic [SubW-1:0] SubLast = SubW'(TICKS_PER_SECOND - 1);

  always_comb begin
    st_o  = st_i;
    sub_o = sub_i;
    rsp_o = '0;

    if (req_i.opcode == hrtoc_pkg::OP_COMMAND) begin
      // mode command; undefined modes leave everything alone
      if (req_i.mode <= hrtoc_pkg::MODE_CUSTOM) begin
        st_o.mode      = req_i.mode;
        st_o.secs_done = '0;
        sub_o          = '0;
        if (req_i.mode == hrtoc_pkg::MODE_OFF) begin
          st_o.sync_armed = 1'b0;
          st_o.timer_run  = 1'b0;
          if (st_i.cmd_rec != hrtoc_pkg::MODE_OFF) begin
            st_o.relay_start = 1'b0;
            st_o.relay_sync  = 1'b0;
          end
        end else begin
          st_o.sync_cnt   = sync_delay_ticks_i;
          st_o.sync_armed = 1'b1;
          st_o.timer_run  = (req_i.mode != hrtoc_pkg::MODE_ON);
          if (req_i.mode == hrtoc_pkg::MODE_OFF30) begin
            st_o.secs_total = hrtoc_pkg::OFF30_SECONDS;
          end else if (req_i.mode == hrtoc_pkg::MODE_OFF60) begin
            st_o.secs_total = hrtoc_pkg::OFF60_SECONDS;
          end else if (req_i.mode == hrtoc_pkg::MODE_CUSTOM) begin
            st_o.secs_total = custom_off_seconds_i;
          end
          if (st_i.cmd_rec == hrtoc_pkg::MODE_OFF) begin
            st_o.relay_start = 1'b1;
          end
        end
        st_o.cmd_rec = req_i.mode;
      end
    end else begin
      // sync relay countdown
      if (st_i.sync_armed) begin
        if (st_i.sync_cnt != '0) begin
          st_o.sync_cnt = st_i.sync_cnt - 16'd1;
        end else begin
          st_o.sync_armed = 1'b0;
          st_o.relay_sync = 1'b1;
        end
      end
      // auto-off timer as whole seconds plus sub-second ticks
      if (st_i.timer_run) begin
        if (st_i.secs_done < st_i.secs_total) begin
          if (sub_i == SubLast) begin
            sub_o          = '0;
            st_o.secs_done = st_i.secs_done + 16'd1;
          end else begin
            sub_o = sub_i + SubW'(1);
          end
        end else begin
          st_o.timer_run   = 1'b0;
          st_o.secs_done   = '0;
          sub_o            = '0;
          st_o.mode        = hrtoc_pkg::MODE_OFF;
          st_o.relay_start = 1'b0;
          st_o.relay_sync  = 1'b0;
        end
      end
      // report on a mode change or a whole second of a timed mode
      if (st_o.mode <= hrtoc_pkg::MODE_ON) begin
        if (st_i.rep_rec != st_o.mode) begin
          rsp_o.report_kind = hrtoc_pkg::REPORT_CHANGED;
        end
      end else if (sub_o == '0) begin
        rsp_o.report_kind       = hrtoc_pkg::REPORT_SECONDS;
        rsp_o.remaining_seconds = st_o.secs_total - st_o.secs_done;
      end
      st_o.rep_rec = st_o.mode;
    end

    rsp_o.relay_start = st_o.relay_start;
    rsp_o.relay_sync  = st_o.relay_sync;
    rsp_o.report_mode = st_o.mode;
  end

endmodule

`default_nettype wire

>>> rtl/core/heater_relay_timed_off_controller_core.sv
// ----------------------------------------------------------------------------
// heater_relay_timed_off_controller_core
// Heater relay controller: start relay, sync relays and timed auto-off.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_stall_o / in_data_i, one request is either
//                 a timer tick or a mode command.
//   out channel : out_valid_o / out_stall_i / out_data_o, exactly one result
//                 per request, in request order.
//   cfg channel : cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i,
//                 always ready; index 0 custom off seconds, 1 sync delay.
// Latency: a result is valid the cycle after its request is taken.
// Throughput: one request per cycle while in_stall_o is low; the whole
//   state update is combinational between st_q and the result register.
// The result register frees and reloads in the same cycle, so in_stall_o is
//   high only while a result is held and out_stall_i is high.
// Reset: relays open, mode off, sync armed with zero countdown (the first
//   tick closes the sync relays), config back to 10 s and 100 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module heater_relay_timed_off_controller_core #(
  parameter int unsigned TICKS_PER_SECOND = hrtoc_pkg::TICKS_PER_SECOND
) (
  input  wire  logic                              clk_i,
  input  wire  logic                              rst_ni,
  input  wire  logic                              in_valid_i,
  output logic                                    in_stall_o,
  input  wire  hrtoc_pkg::in_t                    in_data_i,
  output logic                                    out_valid_o,
  input  wire  logic                              out_stall_i,
  output hrtoc_pkg::out_t                         out_data_o,
  input  wire  logic                              cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire  logic [hrtoc_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire  logic [15:0]                       cfg_data_i
);

  localparam int unsigned SubW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

  hrtoc_pkg::state_t st_q, st_d;
  logic [SubW-1:0]   sub_q, sub_d;
  logic [15:0]       custom_off_seconds_q;
  logic [15:0]       sync_delay_ticks_q;
  hrtoc_pkg::out_t   rsp_d;
  hrtoc_pkg::out_t   out_q;
  logic              out_valid_q;
  logic              in_take;

  // request taken when the result slot is empty or drains this cycle
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      custom_off_seconds_q <= hrtoc_pkg::CUSTOM_OFF_SECONDS_RST;
      sync_delay_ticks_q   <= hrtoc_pkg::SYNC_DELAY_TICKS_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == hrtoc_pkg::CFG_CUSTOM_OFF_SECONDS) begin
        custom_off_seconds_q <= cfg_data_i;
      end else if (cfg_index_i == hrtoc_pkg::CFG_SYNC_DELAY_TICKS) begin
        sync_delay_ticks_q <= cfg_data_i;
      end
    end
  end

  hrtoc_step #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_step (
    .req_i               (in_data_i),
    .st_i                (st_q),
    .sub_i               (sub_q),
    .custom_off_seconds_i(custom_off_seconds_q),
    .sync_delay_ticks_i  (sync_delay_ticks_q),
    .st_o                (st_d),
    .sub_o               (sub_d),
    .rsp_o               (rsp_d)
  );

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= hrtoc_pkg::STATE_RST;
      sub_q <= '0;
    end else if (in_take) begin
      st_q  <= st_d;
      sub_q <= sub_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/hrtoc_checker.sv
// ----------------------------------------------------------------------------
// hrtoc_checker
// Port-level checks of the heater relay controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hrtoc_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_stall_o,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire hrtoc_pkg::out_t out_data_o
);

  // a taken request always yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("taken request gave no result");

  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // seconds are only reported with a seconds report
  a_seconds_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.report_kind != hrtoc_pkg::REPORT_SECONDS)
      |-> (out_data_o.remaining_seconds == 16'd0))
    else $error("remaining seconds without a seconds report");

  // a held result does not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind heater_relay_timed_off_controller_core hrtoc_checker u_hrtoc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heater relay controller core. Tick and mode
// requests go in with random bursts and gaps while the result side stalls
// on its own pattern; every result is compared field by field against a
// cycle-free model of relay levels, mode, reports and countdown.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 2;
  localparam int PHASE_REQUESTS = 8;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  hrtoc_pkg::in_t                    in_data = '0;
  logic                              in_stall;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  hrtoc_pkg::out_t                   out_data;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [hrtoc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]                       cfg_data = '0;

  // model of the controller, reset values
  logic [15:0] custom_secs_q = hrtoc_pkg::CUSTOM_OFF_SECONDS_RST;
  logic [15:0] sync_delay_q  = hrtoc_pkg::SYNC_DELAY_TICKS_RST;
  logic [2:0]  mode_q        = hrtoc_pkg::MODE_OFF;
  logic [2:0]  cmd_rec_q     = hrtoc_pkg::MODE_OFF;
  logic [2:0]  rep_rec_q     = hrtoc_pkg::MODE_OFF;
  logic [15:0] sync_cnt_q    = '0;
  logic        sync_armed_q  = 1'b1;
  logic        timer_run_q   = 1'b0;
  logic [25:0] elapsed_q     = '0;
  logic [25:0] period_q      = '0;
  logic        relay_start_q = 1'b0;
  logic        relay_sync_q  = 1'b0;

  hrtoc_pkg::out_t awaited_status[$];
  int   fail_count  = 0;
  int   idle_cycles = 0;
  int   burst_left  = 0;
  int   stall_window = 0;
  bit   stall_quiet  = 1'b1;

  heater_relay_timed_off_controller_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advance the controller model by one request and return its result
  function automatic hrtoc_pkg::out_t predict_relay_status(hrtoc_pkg::in_t req);
    hrtoc_pkg::out_t res;
    logic [1:0]      kind;
    logic [15:0]     secs;
    kind = hrtoc_pkg::REPORT_NONE;
    secs = '0;
    if (req.opcode == hrtoc_pkg::OP_COMMAND) begin
      // undefined modes leave everything alone
      if (req.mode <= hrtoc_pkg::MODE_CUSTOM) begin
        mode_q    = req.mode;
        elapsed_q = '0;
        if (req.mode == hrtoc_pkg::MODE_OFF) begin
          sync_armed_q = 1'b0;
          timer_run_q  = 1'b0;
          if (cmd_rec_q != hrtoc_pkg::MODE_OFF) begin
            relay_start_q = 1'b0;
            relay_sync_q  = 1'b0;
          end
        end else begin
          sync_cnt_q   = sync_delay_q;
          sync_armed_q = 1'b1;
          timer_run_q  = (req.mode != hrtoc_pkg::MODE_ON);
          case (req.mode)
            hrtoc_pkg::MODE_OFF30:
              period_q = 26'(hrtoc_pkg::OFF30_SECONDS * hrtoc_pkg::TICKS_PER_SECOND);
            hrtoc_pkg::MODE_OFF60:
              period_q = 26'(hrtoc_pkg::OFF60_SECONDS * hrtoc_pkg::TICKS_PER_SECOND);
            hrtoc_pkg::MODE_CUSTOM:
              period_q = 26'(custom_secs_q * hrtoc_pkg::TICKS_PER_SECOND);
            default: ;
          endcase
          // start relay only closes when leaving a commanded off
          if (cmd_rec_q == hrtoc_pkg::MODE_OFF) relay_start_q = 1'b1;
        end
        cmd_rec_q = req.mode;
      end
    end else begin
      // sync countdown runs on even after an auto-off
      if (sync_armed_q) begin
        if (sync_cnt_q != 0) begin
          sync_cnt_q = sync_cnt_q - 16'd1;
        end else begin
          sync_armed_q = 1'b0;
          relay_sync_q = 1'b1;
        end
      end
      // timed mode, auto-off keeps the command record
      if (timer_run_q) begin
        if (elapsed_q < period_q) begin
          elapsed_q = elapsed_q + 26'd1;
        end else begin
          timer_run_q   = 1'b0;
          elapsed_q     = '0;
          mode_q        = hrtoc_pkg::MODE_OFF;
          relay_start_q = 1'b0;
          relay_sync_q  = 1'b0;
        end
      end
      if (mode_q <= hrtoc_pkg::MODE_ON) begin
        if (rep_rec_q != mode_q) kind = hrtoc_pkg::REPORT_CHANGED;
      end else if ((elapsed_q % hrtoc_pkg::TICKS_PER_SECOND) == 0) begin
        kind = hrtoc_pkg::REPORT_SECONDS;
        if (period_q >= elapsed_q)
          secs = 16'((period_q - elapsed_q) / hrtoc_pkg::TICKS_PER_SECOND);
      end
      rep_rec_q = mode_q;
    end
    res.relay_start       = relay_start_q;
    res.relay_sync        = relay_sync_q;
    res.report_kind       = kind;
    res.report_mode       = mode_q;
    res.remaining_seconds = secs;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result checking and watchdog
  always @(posedge clk) begin
    hrtoc_pkg::out_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else if (out_valid && !out_stall) begin
        if (awaited_status.size() == 0) begin
          $display("%0t: result with no request pending, expected none actual %p",
                   $time, out_data);
          fail_count++;
        end else begin
          want = awaited_status.pop_front();
          check_field("relay_start", 16'(want.relay_start), 16'(out_data.relay_start));
          check_field("relay_sync", 16'(want.relay_sync), 16'(out_data.relay_sync));
          check_field("report_kind", 16'(want.report_kind), 16'(out_data.report_kind));
          check_field("report_mode", 16'(want.report_mode), 16'(out_data.report_mode));
          check_field("remaining_seconds", want.remaining_seconds,
                      out_data.remaining_seconds);
        end
      end
    end
  end

  // result side stall pattern: quiet windows and busy windows
  always @(posedge clk) begin
    if (stall_window == 0) begin
      stall_window <= $urandom_range(32, 256);
      stall_quiet  <= ($urandom_range(0, 2) == 0);
    end else begin
      stall_window <= stall_window - 1;
    end
    out_stall <= !stall_quiet && ($urandom_range(0, 99) < 40);
  end

  // send one request, idling between bursts
  task automatic send_request(input hrtoc_pkg::in_t req);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_status.push_back(predict_relay_status(req));
  endtask

  task automatic send_tick();
    hrtoc_pkg::in_t req;
    req.opcode = hrtoc_pkg::OP_TICK;
    req.mode   = 3'($urandom_range(0, 7));
    send_request(req);
  endtask

  task automatic send_command(input logic [2:0] mode);
    hrtoc_pkg::in_t req;
    req.opcode = hrtoc_pkg::OP_COMMAND;
    req.mode   = mode;
    send_request(req);
  endtask

  // stop sending and let every pending result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_status.size() != 0) @(posedge clk);
  endtask

  // write both registers back to back while the block is idle
  task automatic configure(input logic [15:0] custom_secs, input logic [15:0] delay_ticks);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= hrtoc_pkg::CFG_CUSTOM_OFF_SECONDS;
    cfg_data  <= custom_secs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    custom_secs_q = custom_secs;
    cfg_index <= hrtoc_pkg::CFG_SYNC_DELAY_TICKS;
    cfg_data  <= delay_ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sync_delay_q = delay_ticks;
    cfg_valid <= 1'b0;
  endtask

  // armed sync after reset, off with off record, undefined modes
  task automatic test_power_up();
    send_tick();
    send_command(hrtoc_pkg::MODE_OFF);
    send_tick();
    for (int m = int'(hrtoc_pkg::MODE_CUSTOM) + 1; m < 8; m++) send_command(3'(m));
    send_tick();
  endtask

  // every mode, sync delay and on/off change reports
  task automatic test_mode_commands();
    configure(16'd7, 16'd2);
    send_command(hrtoc_pkg::MODE_ON);
    repeat (3) send_tick();
    send_command(hrtoc_pkg::MODE_OFF);
    send_tick();
    send_command(hrtoc_pkg::MODE_OFF30);
    send_tick();
    send_command(hrtoc_pkg::MODE_OFF60);
    send_tick();
    send_command(hrtoc_pkg::MODE_CUSTOM);
    send_tick();
    send_command(hrtoc_pkg::MODE_ON);
    send_tick();
  endtask

  // zero length custom timer, pending sync after auto-off, stale record
  task automatic test_auto_off();
    configure(16'd0, 16'd4);
    send_command(hrtoc_pkg::MODE_OFF);
    send_command(hrtoc_pkg::MODE_CUSTOM);
    repeat (6) send_tick();
    send_command(hrtoc_pkg::MODE_ON);
    send_tick();
  endtask

  // one full second of a custom timer: seconds report, then auto-off
  task automatic test_countdown();
    configure(16'd1, 16'd300);
    send_command(hrtoc_pkg::MODE_CUSTOM);
    repeat (1001) send_tick();
    send_command(hrtoc_pkg::MODE_OFF30);
    send_tick();
    send_command(hrtoc_pkg::MODE_OFF);
    send_tick();
  endtask

  // command then tick burst sequences, mixed with random noise requests
  task automatic test_random_traffic();
    int             sent;
    int             burst;
    hrtoc_pkg::in_t req;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: configure(16'd0, 16'd0);
        1: configure(16'hFFFF, 16'hFFFF);
        default: configure(($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 600)),
                           16'($urandom_range(0, 40)));
      endcase
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        if ($urandom_range(0, 9) < 2) begin
          req.opcode = 1'($urandom_range(0, 1));
          req.mode   = 3'($urandom_range(0, 7));
          send_request(req);
          sent++;
        end else begin
          if ($urandom_range(0, 9) == 0)
            send_command(3'($urandom_range(int'(hrtoc_pkg::MODE_CUSTOM) + 1, 7)));
          else
            send_command(3'($urandom_range(int'(hrtoc_pkg::MODE_OFF),
                                           int'(hrtoc_pkg::MODE_CUSTOM))));
          sent++;
          burst = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 60);
          repeat (burst) send_tick();
          sent += burst;
        end
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_up();
    test_mode_commands();
    test_auto_off();
    test_countdown();
    test_random_traffic();
    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
